FILE: hdl/pngr_pkg.sv
// Shared types, widths and register codes for the peak normalize and gain ramp block.
`timescale 1ns / 1ps

package pngr_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_BITS      = 24;
   localparam int PEAK_BITS      = SAMPLE_BITS - 1;
   localparam int LEN_BITS       = 17;
   localparam int CHAN_CNT_BITS  = 2;
   localparam int FRAC_BITS      = 16;
   localparam int DIV_BITS       = 40;
   localparam int DIVISOR_BITS   = 23;
   localparam int ACC_BITS       = 42;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int MAX_FRAMES_DEF = 65536;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [GAIN_BITS-1:0]          gain_type;
   typedef logic [PEAK_BITS-1:0]          peak_type;
   typedef logic [DIV_BITS-1:0]           dividend_type;
   typedef logic [DIVISOR_BITS-1:0]       divisor_type;
   typedef logic [CSR_IDX_BITS-1:0]       csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0]      csr_data_type;

   // Gain of exactly 1.0 and the largest gain, both Q8.16.
   localparam gain_type GAIN_ONE = gain_type'(1) << FRAC_BITS;
   localparam gain_type GAIN_MAX = '1;

   // Numerator of the normalize reciprocal: 1.0 in Q1.23 times 1.0 in Q8.16.
   localparam dividend_type RECIP_NUM = dividend_type'(1) << (SAMPLE_BITS - 1 + FRAC_BITS);

   // Configuration register indexes.
   localparam csr_idx_type CSR_GAIN_MODE     = 3'd0;
   localparam csr_idx_type CSR_START_GAIN    = 3'd1;
   localparam csr_idx_type CSR_END_GAIN      = 3'd2;
   localparam csr_idx_type CSR_PEAK_FLOOR    = 3'd3;
   localparam csr_idx_type CSR_SEL_LENGTH    = 3'd4;
   localparam csr_idx_type CSR_CHANNEL_COUNT = 3'd5;

   // Start command for the shared divider.
   typedef struct packed {
      logic         start;
      dividend_type dividend;
      divisor_type  divisor;
   } div_req_type;

   // What one lane gives after scaling.
   typedef struct packed {
      sample_type value;
      logic       clip;
   } lane_res_type;

   // Merged result of both lanes.
   typedef struct packed {
      sample_type scaled_a;
      sample_type scaled_b;
      logic       clipped;
   } frame_res_type;

endpackage

FILE: hdl/pngr_ifs.sv
// Handshake interfaces for the request, response and register write channels.
`timescale 1ns / 1ps

interface pngr_req_if import pngr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       req_type;
   sample_type sample_a;
   sample_type sample_b;
   logic       frame_last;

   modport source (output valid, req_type, sample_a, sample_b, frame_last, input ready);
   modport sink (input valid, req_type, sample_a, sample_b, frame_last, output ready);
   modport monitor (input valid, ready, req_type, sample_a, sample_b, frame_last);
endinterface

interface pngr_rsp_if import pngr_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type scaled_a;
   sample_type scaled_b;
   logic       clipped;
   logic       pass_end;

   modport source (output valid, scaled_a, scaled_b, clipped, pass_end, input ready);
   modport sink (input valid, scaled_a, scaled_b, clipped, pass_end, output ready);
   modport monitor (input valid, ready, scaled_a, scaled_b, clipped, pass_end);
endinterface

interface pngr_csr_if import pngr_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

FILE: hdl/pngr_lane.sv
// One channel lane: absolute value for the peak scan and a registered gain multiply.
`timescale 1ns / 1ps

module pngr_lane import pngr_pkg::*; (
   input  logic         clock,
   input  sample_type   sample,
   input  logic         active,
   input  gain_type     gain,
   input  logic         load,
   output peak_type     mag,
   output lane_res_type res
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam logic signed [PROD_BITS-1:0] S_MAX =
      PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PROD_BITS-1:0] S_MIN = -S_MAX - PROD_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
      PROD_BITS'(1) << (FRAC_BITS - 1);

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] rnd;
   logic [SAMPLE_BITS-1:0]      abs_raw;

   // Magnitude of the sample; full negative scale saturates to the largest positive.
   always_comb begin
      abs_raw = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
      if (!active) begin
         mag = '0;
      end else if (abs_raw[SAMPLE_BITS-1]) begin
         mag = '1;
      end else begin
         mag = abs_raw[PEAK_BITS-1:0];
      end
   end

   // Product of Q1.23 sample and unsigned Q8.16 gain.
   assign prod_in = load ? PROD_BITS'(sample) * $signed(PROD_BITS'(gain)) : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Round to nearest with ties up, then saturate to the sample range.
   always_comb begin
      rnd       = (prod_ff + ROUND_BIAS) >>> FRAC_BITS;
      res.value = rnd[SAMPLE_BITS-1:0];
      res.clip  = 1'b0;
      if (rnd > S_MAX) begin
         res.value = S_MAX[SAMPLE_BITS-1:0];
         res.clip  = 1'b1;
      end else if (rnd < S_MIN) begin
         res.value = S_MIN[SAMPLE_BITS-1:0];
         res.clip  = 1'b1;
      end
      if (!active) begin
         res = '0;
      end
   end

endmodule

FILE: hdl/pngr_merge.sv
// Merging stage: folds the lane magnitudes into the peak and joins the lane results.
`timescale 1ns / 1ps

module pngr_merge import pngr_pkg::*; (
   input  peak_type      base_peak,
   input  peak_type      mag_a,
   input  peak_type      mag_b,
   input  lane_res_type  res_a,
   input  lane_res_type  res_b,
   input  logic          gain_clip,
   output peak_type      new_peak,
   output frame_res_type frame
);

   peak_type lane_max;

   // Largest of the running peak and both lane magnitudes.
   always_comb begin
      lane_max = (mag_a > mag_b) ? mag_a : mag_b;
      new_peak = (lane_max > base_peak) ? lane_max : base_peak;
   end

   // Any saturation in a lane or in the gain marks the frame as clipped.
   always_comb begin
      frame.scaled_a = res_a.value;
      frame.scaled_b = res_b.value;
      frame.clipped  = res_a.clip | res_b.clip | gain_clip;
   end

endmodule

FILE: hdl/pngr_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pngr_div import pngr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output logic         done,
   output dividend_type quotient
);

   localparam int CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   divisor_type             rem_ff, rem_in;
   divisor_type             dsr_ff, dsr_in;
   dividend_type            quo_ff, quo_in;
   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   diff;
   logic                    fits;

   // Shift in the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/peak_normalize_gain_ramp.sv
// Top level of the peak normalize and linear gain ramp block.
//
//  channel   direction  carries                                      takes a request when
//  req_chan  in         req_type, sample_a, sample_b, frame_last     valid and ready
//  rsp_chan  out        scaled_a, scaled_b, clipped, pass_end        valid and ready
//  csr_chan  in         index, data (register write)                 valid (ready is held high)
//
// A scan request passes through ST_PREP; an apply request passes through ST_PREP, ST_MUL and
// ST_OUT; one request at a time. An apply request that starts a pass also runs the step
// division in ST_STEP unless the length is zero, in either mode. In normalize mode an apply
// request also runs the reciprocal division in ST_RECIP after any scan request or register
// write, unless peak and floor are both zero. A full response register stalls only ST_OUT.
// Synchronous reset restores the register defaults and ends any pass; no clearing pass.
`timescale 1ns / 1ps

module peak_normalize_gain_ramp import pngr_pkg::*; #(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input logic       clock,
   input logic       reset,
   pngr_req_if.sink  req_chan,
   pngr_rsp_if.source rsp_chan,
   pngr_csr_if.sink  csr_chan
);

   localparam int FP_BITS  = $clog2(MAX_FRAMES + 1);
   localparam int CMP_BITS = (FP_BITS > LEN_BITS) ? FP_BITS : LEN_BITS;
   localparam logic [CMP_BITS-1:0] MAX_C  = CMP_BITS'(MAX_FRAMES);
   localparam logic [FP_BITS-1:0]  FP_MAX = FP_BITS'(MAX_FRAMES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_RECIP = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // Sequencer and captured request.
   logic [2:0]           state_ff, state_in;
   logic                 is_apply_ff, is_apply_in;
   sample_type           samp_a_ff, samp_a_in;
   sample_type           samp_b_ff, samp_b_in;
   logic                 last_ff, last_in;

   // Configuration registers.
   logic                 gain_mode_ff, gain_mode_in;
   gain_type             start_gain_ff, start_gain_in;
   gain_type             end_gain_ff, end_gain_in;
   peak_type             peak_floor_ff, peak_floor_in;
   logic [LEN_BITS-1:0]  sel_len_ff, sel_len_in;
   logic [CHAN_CNT_BITS-1:0] chan_cnt_ff, chan_cnt_in;

   // Pass state.
   peak_type             peak_ff, peak_in;
   logic [FP_BITS-1:0]   frame_pos_ff, frame_pos_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic signed [ACC_BITS-1:0] step_ff, step_in;
   logic                 pass_active_ff, pass_active_in;
   gain_type             recip_ff, recip_in;
   logic                 recip_clip_ff, recip_clip_in;
   logic                 recip_valid_ff, recip_valid_in;
   logic                 gclip_ff, gclip_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   frame_res_type        rsp_frame_ff, rsp_frame_in;
   logic                 rsp_end_ff, rsp_end_in;

   // Datapath signals.
   logic                 two_chan;
   peak_type             eff_peak;
   logic [CMP_BITS-1:0]  sel_c;
   logic [CMP_BITS-1:0]  len_c;
   logic                 diff_neg;
   gain_type             diff_mag;
   logic                 need_recip;
   logic [FP_BITS-1:0]   fp_base;
   logic [FP_BITS-1:0]   fp_next;
   logic [ACC_BITS-FRAC_BITS-2:0] acc_gain;
   gain_type             gain_sel;
   logic                 gain_clip_sel;
   peak_type             base_peak;
   peak_type             mag_a, mag_b, new_peak;
   lane_res_type         res_a, res_b;
   frame_res_type        merged;
   div_req_type          div_req;
   logic                 div_done;
   dividend_type         div_quo;
   logic                 rsp_free;

   // Effective length, channel mode and fade difference.
   always_comb begin
      two_chan = chan_cnt_ff[1];
      eff_peak = (peak_ff > peak_floor_ff) ? peak_ff : peak_floor_ff;
      sel_c    = CMP_BITS'(sel_len_ff);
      len_c    = (sel_c > MAX_C) ? MAX_C : sel_c;
      diff_neg = end_gain_ff < start_gain_ff;
      diff_mag = diff_neg ? (start_gain_ff - end_gain_ff) : (end_gain_ff - start_gain_ff);
      need_recip = gain_mode_ff && (eff_peak != '0) && !recip_valid_ff;
      fp_base  = pass_active_ff ? frame_pos_ff : '0;
      fp_next  = (fp_base < FP_MAX) ? (fp_base + 1'b1) : fp_base;
      base_peak = pass_active_ff ? peak_ff : '0;
      rsp_free = !rsp_valid_ff || rsp_chan.ready;
   end

   // Gain for the current apply frame.
   always_comb begin
      acc_gain      = acc_ff[ACC_BITS-2:FRAC_BITS];
      gain_sel      = GAIN_ONE;
      gain_clip_sel = 1'b0;
      if (gain_mode_ff) begin
         if (eff_peak != '0) begin
            gain_sel      = recip_ff;
            gain_clip_sel = recip_clip_ff;
         end
      end else if (acc_ff[ACC_BITS-1]) begin
         gain_sel = '0;
      end else if (acc_gain > (ACC_BITS-FRAC_BITS-1)'(GAIN_MAX)) begin
         gain_sel      = GAIN_MAX;
         gain_clip_sel = 1'b1;
      end else begin
         gain_sel = acc_gain[GAIN_BITS-1:0];
      end
   end

   // Two lanes, one per channel, and the merging stage.
   pngr_lane u_lane_a (
      .clock  (clock),
      .sample (samp_a_ff),
      .active (1'b1),
      .gain   (gain_sel),
      .load   (state_ff == ST_MUL),
      .mag    (mag_a),
      .res    (res_a)
   );

   pngr_lane u_lane_b (
      .clock  (clock),
      .sample (samp_b_ff),
      .active (two_chan),
      .gain   (gain_sel),
      .load   (state_ff == ST_MUL),
      .mag    (mag_b),
      .res    (res_b)
   );

   pngr_merge u_merge (
      .base_peak (base_peak),
      .mag_a     (mag_a),
      .mag_b     (mag_b),
      .res_a     (res_a),
      .res_b     (res_b),
      .gain_clip (gclip_ff),
      .new_peak  (new_peak),
      .frame     (merged)
   );

   pngr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next-state logic for the sequencer, configuration and pass state.
   always_comb begin
      state_in       = state_ff;
      is_apply_in    = is_apply_ff;
      samp_a_in      = samp_a_ff;
      samp_b_in      = samp_b_ff;
      last_in        = last_ff;
      gain_mode_in   = gain_mode_ff;
      start_gain_in  = start_gain_ff;
      end_gain_in    = end_gain_ff;
      peak_floor_in  = peak_floor_ff;
      sel_len_in     = sel_len_ff;
      chan_cnt_in    = chan_cnt_ff;
      peak_in        = peak_ff;
      frame_pos_in   = frame_pos_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      pass_active_in = pass_active_ff;
      recip_in       = recip_ff;
      recip_clip_in  = recip_clip_ff;
      recip_valid_in = recip_valid_ff;
      gclip_in       = gclip_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_end_in     = rsp_end_ff;
      div_req        = '0;

      // Register writes; any write may move the floor, so drop the cached reciprocal.
      if (csr_chan.valid) begin
         recip_valid_in = 1'b0;
         case (csr_chan.index)
            CSR_GAIN_MODE:     gain_mode_in  = csr_chan.data[0];
            CSR_START_GAIN:    start_gain_in = csr_chan.data[GAIN_BITS-1:0];
            CSR_END_GAIN:      end_gain_in   = csr_chan.data[GAIN_BITS-1:0];
            CSR_PEAK_FLOOR:    peak_floor_in = csr_chan.data[PEAK_BITS-1:0];
            CSR_SEL_LENGTH:    sel_len_in    = csr_chan.data[LEN_BITS-1:0];
            CSR_CHANNEL_COUNT: chan_cnt_in   = csr_chan.data[CHAN_CNT_BITS-1:0];
            default: begin
            end
         endcase
      end

      // The response register empties when the sink takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               is_apply_in = req_chan.req_type;
               samp_a_in   = req_chan.sample_a;
               samp_b_in   = req_chan.sample_b;
               last_in     = req_chan.frame_last;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            if (!is_apply_ff) begin
               // Scan frame: fold the lane magnitudes into the peak.
               peak_in        = new_peak;
               frame_pos_in   = fp_next;
               pass_active_in = !last_ff;
               recip_valid_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               // Apply frame: a new pass loads the ramp and, for a nonzero length, divides for its step.
               if (!pass_active_ff) begin
                  acc_in         = ACC_BITS'(start_gain_ff) <<< FRAC_BITS;
                  step_in        = '0;
                  frame_pos_in   = '0;
                  pass_active_in = 1'b1;
               end
               if (!pass_active_ff && (len_c != '0)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {diff_mag, FRAC_BITS'(0)};
                  div_req.divisor  = DIVISOR_BITS'(len_c[LEN_BITS-1:0]);
                  state_in         = ST_STEP;
               end else if (need_recip) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = RECIP_NUM;
                  div_req.divisor  = DIVISOR_BITS'(eff_peak);
                  state_in         = ST_RECIP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_STEP: begin
            if (div_done) begin
               step_in = diff_neg ? -$signed(ACC_BITS'(div_quo)) : $signed(ACC_BITS'(div_quo));
               if (need_recip) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = RECIP_NUM;
                  div_req.divisor  = DIVISOR_BITS'(eff_peak);
                  state_in         = ST_RECIP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_RECIP: begin
            if (div_done) begin
               if (div_quo > DIV_BITS'(GAIN_MAX)) begin
                  recip_in      = GAIN_MAX;
                  recip_clip_in = 1'b1;
               end else begin
                  recip_in      = div_quo[GAIN_BITS-1:0];
                  recip_clip_in = 1'b0;
               end
               recip_valid_in = 1'b1;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            gclip_in = gain_clip_sel;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Deliver the scaled frame and advance the ramp.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = merged;
               rsp_end_in   = last_ff;
               if (CMP_BITS'(frame_pos_ff) < len_c) begin
                  acc_in = acc_ff + step_ff;
               end
               frame_pos_in   = fp_next;
               pass_active_in = !last_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gain_mode_ff   <= 1'b1;
         start_gain_ff  <= GAIN_ONE;
         end_gain_ff    <= GAIN_ONE;
         peak_floor_ff  <= '0;
         sel_len_ff     <= LEN_BITS'(1);
         chan_cnt_ff    <= CHAN_CNT_BITS'(2);
         peak_ff        <= '0;
         frame_pos_ff   <= '0;
         acc_ff         <= '0;
         step_ff        <= '0;
         pass_active_ff <= 1'b0;
         recip_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_mode_ff   <= gain_mode_in;
         start_gain_ff  <= start_gain_in;
         end_gain_ff    <= end_gain_in;
         peak_floor_ff  <= peak_floor_in;
         sel_len_ff     <= sel_len_in;
         chan_cnt_ff    <= chan_cnt_in;
         peak_ff        <= peak_in;
         frame_pos_ff   <= frame_pos_in;
         acc_ff         <= acc_in;
         step_ff        <= step_in;
         pass_active_ff <= pass_active_in;
         recip_valid_ff <= recip_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      is_apply_ff   <= is_apply_in;
      samp_a_ff     <= samp_a_in;
      samp_b_ff     <= samp_b_in;
      last_ff       <= last_in;
      recip_ff      <= recip_in;
      recip_clip_ff <= recip_clip_in;
      gclip_ff      <= gclip_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // Port drive.
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.scaled_a = rsp_frame_ff.scaled_a;
   assign rsp_chan.scaled_b = rsp_frame_ff.scaled_b;
   assign rsp_chan.clipped  = rsp_frame_ff.clipped;
   assign rsp_chan.pass_end = rsp_end_ff;

endmodule

FILE: hdl/pngr_check.sv
// Port-level checks for the peak normalize and gain ramp block, bound to its top level.
`timescale 1ns / 1ps

module pngr_check import pngr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_scaled_a,
   input sample_type rsp_scaled_b,
   input logic       rsp_clipped,
   input logic       rsp_pass_end
);

   // A waiting response is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_scaled_a) && $stable(rsp_scaled_b) &&
         $stable(rsp_clipped) && $stable(rsp_pass_end))
      else $error("stalled response changed");

   // One request is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // A scan request never produces a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type && !rsp_valid |=> !rsp_valid)
      else $error("scan request produced a response");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind peak_normalize_gain_ramp pngr_check u_pngr_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_type     (req_chan.req_type),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_scaled_a (rsp_chan.scaled_a),
   .rsp_scaled_b (rsp_chan.scaled_b),
   .rsp_clipped  (rsp_chan.clipped),
   .rsp_pass_end (rsp_chan.pass_end)
);
